@@ hdl/mwal_pkg.sv @@
// Package for the max-weight assignment label core.
// Holds default sizes, result kind codes, sequencer states and the ALU flag struct.
// No dependencies.
package mwal_pkg;

    localparam int MAX_SIZE_DEF    = 16;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int VALUE_W         = 22;
    localparam int CFG_W           = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
    localparam longint VALUE_MAX = 64'sd2097151;
    localparam longint VALUE_MIN = -64'sd2097152;

    typedef enum logic [1:0] {
        KIND_ROW   = 2'd0,
        KIND_COL   = 2'd1,
        KIND_TOTAL = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAX_RD,
        S_MAX_EV,
        S_ROW_INIT,
        S_RND_INIT,
        S_DFS_RD,
        S_DFS_EV,
        S_UNWIND,
        S_MIN,
        S_UPD,
        S_ROW_NEXT,
        S_EMIT,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic zero;
        logic neg;
    } t_alu_flags;

endpackage

@@ hdl/mwal_alu.sv @@
// Shared add-subtract-compare unit of the assignment core: res = a + b - c.
// Depends on mwal_pkg.
module mwal_alu #(
    parameter int W = 24
) (
    input  logic signed [W-1:0]  i_a,
    input  logic signed [W-1:0]  i_b,
    input  logic signed [W-1:0]  i_c,
    output logic signed [W-1:0]  o_res,
    output mwal_pkg::t_alu_flags o_flags
);
    import mwal_pkg::*;

    assign o_res        = i_a + i_b - i_c;
    assign o_flags.zero = (o_res == '0);
    assign o_flags.neg  = o_res[W-1];

endmodule

@@ hdl/max_weight_assignment_labels_core.sv @@
// Top level of the max-weight assignment label core (Kuhn-Munkres with DFS augmentation).
// Depends on mwal_pkg and mwal_alu.
//
// Weights are taken one per cycle while o_busy is low and i_start is high. On the N*N-th
// element the core goes busy and solves: a row-maximum pass, then label rounds per row. Each
// round has a setup, a search in which each tested tight or slack edge takes a registered
// weight-memory read and then the shared adder, then the slack minimum and label update;
// a row runs at most 2*MAX_SIZE+2 rounds. Results then come out one per cycle on o_valid:
// N row labels, N column labels, then the total with o_last, and the receiver cannot stall
// them. A clear state then resets the core before the next matrix is taken. The adder and
// the single weight-memory read port set the solve time.
module max_weight_assignment_labels_core #(
    parameter int MAX_SIZE    = mwal_pkg::MAX_SIZE_DEF,
    parameter int WEIGHT_BITS = mwal_pkg::WEIGHT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_weight,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_index,
    output logic [21:0] o_value,
    output logic        o_last
);
    import mwal_pkg::*;

    localparam int IW     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SW     = $clog2(MAX_SIZE + 1);
    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int LW     = WEIGHT_BITS + IW + 3;
    localparam int TW     = LW + SW;
    localparam int ROUNDS = 2 * MAX_SIZE + 2;
    localparam int RW     = $clog2(ROUNDS + 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_cfg;
    logic [CW-1:0]     r_count;
    logic [WEIGHT_BITS-1:0] r_mem [DEPTH];
    logic [WEIGHT_BITS-1:0] r_rdata;

    logic signed [LW-1:0] r_rl    [MAX_SIZE];
    logic signed [LW-1:0] r_cl    [MAX_SIZE];
    logic signed [LW-1:0] r_slack [MAX_SIZE];
    logic [SW-1:0]        r_partner [MAX_SIZE];
    logic [MAX_SIZE-1:0]  r_slack_v, r_rvis, r_cvis;
    logic [IW-1:0]        r_stk_row [MAX_SIZE];
    logic [IW-1:0]        r_stk_col [MAX_SIZE];
    logic [SW-1:0]        r_sp;
    logic [SW-1:0]        r_row;
    logic [SW-1:0]        r_col;
    logic signed [LW-1:0] r_best;
    logic signed [LW-1:0] r_d;
    logic                 r_have;
    logic [RW-1:0]        r_round;
    logic [SW:0]          r_emit;
    logic signed [TW-1:0] r_total;

    logic [SW-1:0]        w_side;
    logic                 w_accept;
    logic [CW-1:0]        w_cnt_inc;
    logic [2*SW-1:0]      w_sq;
    logic                 w_solve;
    logic [SW-1:0]        w_spm1;
    logic [IW-1:0]        w_top;
    logic [IW-1:0]        w_u;
    logic [IW-1:0]        w_cidx;
    logic [IW-1:0]        w_ridx;
    logic [IW-1:0]        w_arow;
    logic [2*SW-1:0]      w_prod;
    logic [AW-1:0]        w_raddr;
    logic signed [LW-1:0] w_wext;
    logic signed [LW-1:0] w_a, w_b, w_c, w_res;
    t_alu_flags           w_flags;
    logic [SW-1:0]        w_p;
    logic [IW-1:0]        w_pidx;
    logic                 w_free;
    logic                 w_col_end;
    logic                 w_row_last;
    logic                 w_d_bad;
    logic [SW:0]          w_side2;
    logic                 w_emit_lab;
    logic                 w_emit_row;
    logic [IW-1:0]        w_eidx;
    logic signed [LW-1:0] w_lab;
    logic signed [TW-1:0] w_sel;
    logic signed [63:0]   w_v64;

    always_comb begin
        if (r_cfg == '0) begin
            w_side = SW'(1);
        end else if (32'(r_cfg) > 32'(MAX_SIZE)) begin
            w_side = SW'(MAX_SIZE);
        end else begin
            w_side = r_cfg[SW-1:0];
        end
    end

    assign w_accept  = i_start && (r_state == S_IDLE);
    assign w_cnt_inc = r_count + CW'(1);
    assign w_sq      = {{SW{1'b0}}, w_side} * {{SW{1'b0}}, w_side};
    assign w_solve   = ({{(2*SW){1'b0}}, w_cnt_inc} >= {{CW{1'b0}}, w_sq});

    assign w_spm1  = r_sp - SW'(1);
    assign w_top   = w_spm1[IW-1:0];
    assign w_u     = r_stk_row[w_top];
    assign w_cidx  = r_col[IW-1:0];
    assign w_ridx  = r_row[IW-1:0];
    assign w_arow  = (r_state == S_MAX_RD) ? w_ridx : w_u;
    assign w_prod  = {{(2*SW-IW){1'b0}}, w_arow} * {{SW{1'b0}}, w_side}
                   + {{SW{1'b0}}, r_col};
    assign w_raddr = w_prod[AW-1:0];
    assign w_wext  = $signed({{(LW-WEIGHT_BITS){1'b0}}, r_rdata});

    assign w_col_end  = (r_col == w_side);
    assign w_row_last = (r_row + SW'(1) == w_side);
    assign w_d_bad    = !r_have || r_d[LW-1] || (r_d == '0);
    assign w_p        = r_partner[w_cidx];
    assign w_pidx     = IW'(w_p - SW'(1));
    assign w_free     = (w_p == '0) || (w_p > w_side) || r_rvis[w_pidx];
    assign w_side2    = {w_side, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_count[AW-1:0]] <= WEIGHT_BITS'(i_weight);
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        w_a = w_wext;
        w_b = '0;
        w_c = r_best;
        unique case (r_state) inside
            S_DFS_EV: begin
                w_a = r_rl[w_u];
                w_b = r_cl[w_cidx];
                w_c = w_wext;
            end
            S_MIN, S_UPD: begin
                w_a = r_slack[w_cidx];
                w_b = '0;
                w_c = r_d;
            end
            default: begin
                w_a = w_wext;
                w_b = '0;
                w_c = r_best;
            end
        endcase
    end

    mwal_alu #(.W(LW)) u_alu (
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (w_c),
        .o_res   (w_res),
        .o_flags (w_flags)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_accept && w_solve) n_state = S_MAX_RD;
            S_MAX_RD:   begin
                if (!w_col_end) begin
                    n_state = S_MAX_EV;
                end else if (w_row_last) begin
                    n_state = S_ROW_INIT;
                end
            end
            S_MAX_EV:   n_state = S_MAX_RD;
            S_ROW_INIT: n_state = S_RND_INIT;
            S_RND_INIT: n_state = S_DFS_RD;
            S_DFS_RD:   begin
                if (w_col_end) begin
                    if (r_sp == SW'(1)) n_state = S_MIN;
                end else if (!r_cvis[w_cidx]) begin
                    n_state = S_DFS_EV;
                end
            end
            S_DFS_EV:   begin
                if (w_flags.zero && w_free) begin
                    n_state = S_UNWIND;
                end else begin
                    n_state = S_DFS_RD;
                end
            end
            S_UNWIND:   if (r_sp == '0) n_state = S_ROW_NEXT;
            S_MIN:      begin
                if (w_col_end) n_state = w_d_bad ? S_ROW_NEXT : S_UPD;
            end
            S_UPD:      begin
                if (w_col_end) begin
                    n_state = (r_round + RW'(1) == RW'(ROUNDS)) ? S_ROW_NEXT : S_RND_INIT;
                end
            end
            S_ROW_NEXT: n_state = w_row_last ? S_EMIT : S_ROW_INIT;
            S_EMIT:     if (r_emit == w_side2) n_state = S_CLEAR;
            S_CLEAR:    n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= CFG_RESET;
            r_count   <= '0;
            r_slack_v <= '0;
            r_rvis    <= '0;
            r_cvis    <= '0;
            r_sp      <= '0;
            for (int i = 0; i < MAX_SIZE; i++) begin
                r_rl[i]      <= '0;
                r_cl[i]      <= '0;
                r_partner[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) r_count <= w_cnt_inc;
                    r_row  <= '0;
                    r_col  <= '0;
                    r_best <= '0;
                end
                S_MAX_RD: begin
                    if (w_col_end) begin
                        r_rl[w_ridx]      <= r_best;
                        r_cl[w_ridx]      <= '0;
                        r_partner[w_ridx] <= '0;
                        r_row  <= w_row_last ? '0 : r_row + SW'(1);
                        r_col  <= '0;
                        r_best <= '0;
                    end
                end
                S_MAX_EV: begin
                    if (!w_flags.zero && !w_flags.neg) r_best <= w_wext;
                    r_col <= r_col + SW'(1);
                end
                S_ROW_INIT: begin
                    r_slack_v <= '0;
                    r_round   <= '0;
                end
                S_RND_INIT: begin
                    r_rvis         <= MAX_SIZE'(1) << w_ridx;
                    r_cvis         <= '0;
                    r_stk_row[0]   <= w_ridx;
                    r_sp           <= SW'(1);
                    r_col          <= '0;
                end
                S_DFS_RD: begin
                    if (w_col_end) begin
                        if (r_sp == SW'(1)) begin
                            r_sp   <= '0;
                            r_col  <= '0;
                            r_have <= 1'b0;
                        end else begin
                            r_sp  <= w_spm1;
                            r_col <= SW'(r_stk_col[IW'(w_spm1 - SW'(1))]) + SW'(1);
                        end
                    end else if (r_cvis[w_cidx]) begin
                        r_col <= r_col + SW'(1);
                    end
                end
                S_DFS_EV: begin
                    if (w_flags.zero) begin
                        r_cvis[w_cidx] <= 1'b1;
                        if (w_free) begin
                            r_partner[w_cidx] <= SW'(w_u) + SW'(1);
                            r_sp <= w_spm1;
                        end else begin
                            r_stk_col[w_top]          <= w_cidx;
                            r_stk_row[r_sp[IW-1:0]]   <= w_pidx;
                            r_rvis[w_pidx]            <= 1'b1;
                            r_sp  <= r_sp + SW'(1);
                            r_col <= '0;
                        end
                    end else begin
                        if (!r_slack_v[w_cidx] || (w_res < r_slack[w_cidx])) begin
                            r_slack[w_cidx]   <= w_res;
                            r_slack_v[w_cidx] <= 1'b1;
                        end
                        r_col <= r_col + SW'(1);
                    end
                end
                S_UNWIND: begin
                    if (r_sp != '0) begin
                        r_partner[r_stk_col[w_top]] <= SW'(r_stk_row[w_top]) + SW'(1);
                        r_sp <= w_spm1;
                    end
                end
                S_MIN: begin
                    if (w_col_end) begin
                        r_col <= '0;
                    end else begin
                        if (!r_cvis[w_cidx] && r_slack_v[w_cidx] && (!r_have || w_flags.neg)) begin
                            r_d    <= r_slack[w_cidx];
                            r_have <= 1'b1;
                        end
                        r_col <= r_col + SW'(1);
                    end
                end
                S_UPD: begin
                    if (w_col_end) begin
                        r_round <= r_round + RW'(1);
                    end else begin
                        if (r_rvis[w_cidx]) r_rl[w_cidx] <= r_rl[w_cidx] - r_d;
                        if (r_cvis[w_cidx]) begin
                            r_cl[w_cidx] <= r_cl[w_cidx] + r_d;
                        end else if (r_slack_v[w_cidx]) begin
                            r_slack[w_cidx] <= w_res;
                        end
                        r_col <= r_col + SW'(1);
                    end
                end
                S_ROW_NEXT: begin
                    r_row   <= r_row + SW'(1);
                    r_emit  <= '0;
                    r_total <= '0;
                end
                S_EMIT: begin
                    r_emit <= r_emit + (SW+1)'(1);
                    if (w_emit_lab) r_total <= r_total + TW'(w_lab);
                end
                S_CLEAR: begin
                    r_count   <= '0;
                    r_slack_v <= '0;
                    r_rvis    <= '0;
                    r_cvis    <= '0;
                    r_sp      <= '0;
                    for (int i = 0; i < MAX_SIZE; i++) begin
                        r_rl[i]      <= '0;
                        r_cl[i]      <= '0;
                        r_partner[i] <= '0;
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    assign w_emit_lab = (r_emit < w_side2);
    assign w_emit_row = (r_emit < {1'b0, w_side});
    assign w_eidx     = w_emit_row ? r_emit[IW-1:0] : IW'(r_emit - {1'b0, w_side});
    assign w_lab      = w_emit_row ? r_rl[w_eidx] : r_cl[w_eidx];
    assign w_sel      = w_emit_lab ? TW'(w_lab) : r_total;
    assign w_v64      = 64'(w_sel);

    always_comb begin
        o_busy  = (r_state != S_IDLE);
        o_valid = (r_state == S_EMIT);
        o_last  = (r_state == S_EMIT) && !w_emit_lab;
        if (!w_emit_lab) begin
            o_kind  = KIND_TOTAL;
            o_index = '0;
        end else if (w_emit_row) begin
            o_kind  = KIND_ROW;
            o_index = 4'(w_eidx);
        end else begin
            o_kind  = KIND_COL;
            o_index = 4'(w_eidx);
        end
        if (w_v64 > VALUE_MAX) begin
            o_value = VALUE_W'(VALUE_MAX);
        end else if (w_v64 < VALUE_MIN) begin
            o_value = VALUE_W'(VALUE_MIN);
        end else begin
            o_value = w_v64[VALUE_W-1:0];
        end
    end

endmodule

@@ hdl/mwal_checker.sv @@
// Port-level checks for the max-weight assignment label core, bound to the top level.
// Depends on mwal_pkg and max_weight_assignment_labels_core.
module mwal_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_busy,
    input logic       o_valid,
    input logic [1:0] o_kind,
    input logic       o_last
);
    import mwal_pkg::*;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("result transfer while idle");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid) else $error("last without result");

    a_total_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_TOTAL) |-> o_last) else $error("total not marked last");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !o_valid) else $error("result after last");

endmodule

bind max_weight_assignment_labels_core mwal_checker u_mwal_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_kind  (o_kind),
    .o_last  (o_last)
);
